FILE: rtl/kdpm_pkg.sv
`default_nettype none

package kdpm_pkg;

  // Field and register widths
  localparam int unsigned QW      = 32;
  localparam int unsigned STEP_W  = 24;
  localparam int unsigned FRIC_W  = 16;
  localparam int unsigned MOVE_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Register reset values
  localparam logic [STEP_W-1:0] FORCE_STEP_RST      = 24'd65536;
  localparam logic [FRIC_W-1:0] FRICTION_NORMAL_RST = 16'd58982;
  localparam logic [FRIC_W-1:0] FRICTION_BRAKE_RST  = 16'd32768;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORCE_STEP      = 2'd0,
    CFG_FRICTION_NORMAL = 2'd1,
    CFG_FRICTION_BRAKE  = 2'd2
  } cfg_idx_e;

  // Command codes
  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Key codes
  localparam logic [2:0] KEY_LEFT  = 3'd0;
  localparam logic [2:0] KEY_RIGHT = 3'd1;
  localparam logic [2:0] KEY_UP    = 3'd2;
  localparam logic [2:0] KEY_DOWN  = 3'd3;
  localparam logic [2:0] KEY_BRAKE = 3'd4;

  typedef struct packed {
    logic       command;
    logic [2:0] key_code;
    logic       pressed;
  } kdpm_in_t;

  typedef struct packed {
    logic signed [MOVE_W-1:0] move_x;
    logic signed [MOVE_W-1:0] move_y;
  } kdpm_out_t;

  // Per-axis strobes from the pipeline control
  typedef struct packed {
    logic key_en;   // apply a direction key to the force
    logic key_neg;  // subtract the step rather than add it
    logic tick_en;  // velocity update of a tick
    logic pos_en;   // position update of a tick
  } axis_ctrl_t;

  // Clamp a 33-bit signed sum to the signed 32-bit range
  function automatic logic [QW-1:0] sat33(input logic [QW:0] v);
    logic [QW-1:0] r;
    if (v[QW] != v[QW-1]) begin
      r = v[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/key_driven_pointer_motion.sv
// A tick passes the input stage, the position stage and the output register before its move shows.
// Throughput: one beat per cycle on input unless the output stalls; key events and ticks may follow back to back.
// The clock period is set by the velocity loop: add, saturate, 32x17 multiply, round.
// Reset clears forces, velocities, positions and the brake flag, empties the
// pipeline and loads the register defaults; no clearing pass is needed.
`default_nettype none

module key_driven_pointer_motion import kdpm_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire kdpm_in_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output kdpm_out_t                 out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [STEP_W-1:0]    cfg_data_i
);

  logic [STEP_W-1:0] force_step_q;
  logic [FRIC_W-1:0] fric_normal_q;
  logic [FRIC_W-1:0] fric_brake_q;
  logic              brake_q;
  logic              s1_valid_q;
  kdpm_in_t          s1_data_q;
  logic              s2_valid_q;
  logic              out_valid_q;
  kdpm_out_t         out_data_q;
  logic              s1_adv, s2_adv;
  logic              s1_fire, s1_key, s1_tick;
  logic              s2_fire;
  logic              move_nz;
  logic              neg;
  logic [FRIC_W-1:0] fric;
  axis_ctrl_t        ctrl_x, ctrl_y;
  logic signed [MOVE_W-1:0] move_x, move_y;
  cfg_idx_e          cfg_idx;

  // Move a stage on when the one after it is empty or moving
  assign s2_adv     = !out_valid_q || out_ready_i;
  assign s1_adv     = !s2_valid_q || s2_adv;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign cfg_ready_o = 1'b1;

  assign s1_fire = s1_valid_q && s1_adv;
  assign s1_key  = s1_fire && (s1_data_q.command == CMD_KEY);
  assign s1_tick = s1_fire && (s1_data_q.command == CMD_TICK);
  assign s2_fire = s2_valid_q && s2_adv;

  // Left and up pull negative on press, right and down on release
  assign neg  = ((s1_data_q.key_code == KEY_LEFT) || (s1_data_q.key_code == KEY_UP))
                ^ !s1_data_q.pressed;
  assign fric = brake_q ? fric_brake_q : fric_normal_q;

  always_comb begin
    ctrl_x.key_en  = s1_key && ((s1_data_q.key_code == KEY_LEFT) ||
                                (s1_data_q.key_code == KEY_RIGHT));
    ctrl_x.key_neg = neg;
    ctrl_x.tick_en = s1_tick;
    ctrl_x.pos_en  = s2_fire;
    ctrl_y.key_en  = s1_key && ((s1_data_q.key_code == KEY_UP) ||
                                (s1_data_q.key_code == KEY_DOWN));
    ctrl_y.key_neg = neg;
    ctrl_y.tick_en = s1_tick;
    ctrl_y.pos_en  = s2_fire;
  end

  kdpm_axis u_axis_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_x),
    .step_i (force_step_q),
    .fric_i (fric),
    .move_o (move_x)
  );

  kdpm_axis u_axis_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_y),
    .step_i (force_step_q),
    .fric_i (fric),
    .move_o (move_y)
  );

  assign move_nz = (move_x != '0) || (move_y != '0);

  // Write configuration registers; drop writes beyond the list
  assign cfg_idx = cfg_idx_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_step_q  <= FORCE_STEP_RST;
      fric_normal_q <= FRICTION_NORMAL_RST;
      fric_brake_q  <= FRICTION_BRAKE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx)
        CFG_FORCE_STEP:      force_step_q  <= cfg_data_i;
        CFG_FRICTION_NORMAL: fric_normal_q <= cfg_data_i[FRIC_W-1:0];
        CFG_FRICTION_BRAKE:  fric_brake_q  <= cfg_data_i[FRIC_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline valid bits and the brake flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      brake_q     <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        s2_valid_q <= s1_tick;
      end
      if (s2_adv) begin
        out_valid_q <= s2_valid_q && move_nz;
      end
      if (s1_key && (s1_data_q.key_code == KEY_BRAKE)) begin
        brake_q <= s1_data_q.pressed;
      end
    end
  end

  // Capture input beats and result payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
    if (s2_fire) begin
      out_data_q.move_x <= move_x;
      out_data_q.move_y <= move_y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A result beat never carries a null move
  a_out_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.move_x != '0 || out_data_o.move_y != '0))
    else $error("result beat with zero move");

  // A result only comes from a tick in the position stage
  a_out_from_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s2_valid_q))
    else $error("result without a tick in the position stage");

  // The position stage is only filled from the input stage
  a_s2_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s2_valid_q) |-> $past(s1_valid_q && s1_data_q.command == CMD_TICK))
    else $error("position stage filled without a tick");

  // A stalled result holds its payload inside the block
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_data_q)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

FILE: rtl/kdpm_axis.sv
`default_nettype none

module kdpm_axis import kdpm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire axis_ctrl_t         ctrl_i,
  input  wire logic [STEP_W-1:0]  step_i,
  input  wire logic [FRIC_W-1:0]  fric_i,
  output logic signed [MOVE_W-1:0] move_o
);

  logic [QW-1:0]   force_q, force_d;
  logic [QW-1:0]   velocity_q;
  logic [QW-1:0]   vel_stage_q;
  logic [QW-1:0]   subpixel_q, subpixel_d;
  logic [QW:0]     force_sum;
  logic [QW:0]     vel_sum;
  logic [QW-1:0]   vel_sat;
  logic signed [48:0] prod;
  logic signed [48:0] prod_adj;
  logic [QW-1:0]   vel_new;
  logic [QW:0]     pos_sum;
  logic [QW-1:0]   pos_sat;
  logic            frac_neg;

  // Add or remove one force step, saturating
  always_comb begin
    if (ctrl_i.key_neg) begin
      force_sum = {force_q[QW-1], force_q} - {{(QW+1-STEP_W){1'b0}}, step_i};
    end else begin
      force_sum = {force_q[QW-1], force_q} + {{(QW+1-STEP_W){1'b0}}, step_i};
    end
    force_d = sat33(force_sum);
  end

  // Accelerate, then scale by friction truncating toward zero
  always_comb begin
    vel_sum  = {velocity_q[QW-1], velocity_q} + {force_q[QW-1], force_q};
    vel_sat  = sat33(vel_sum);
    prod     = $signed(vel_sat) * $signed({1'b0, fric_i});
    prod_adj = prod + (prod[48] ? 49'sd65535 : 49'sd0);
    vel_new  = prod_adj[47:16];
  end

  // Advance the position and split off whole pixels
  always_comb begin
    pos_sum    = {subpixel_q[QW-1], subpixel_q} + {vel_stage_q[QW-1], vel_stage_q};
    pos_sat    = sat33(pos_sum);
    frac_neg   = pos_sat[QW-1] & (|pos_sat[15:0]);
    move_o     = $signed(pos_sat[QW-1:16] + {{(MOVE_W-1){1'b0}}, frac_neg});
    subpixel_d = {{16{frac_neg}}, pos_sat[15:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_q    <= '0;
      velocity_q <= '0;
      subpixel_q <= '0;
    end else begin
      if (ctrl_i.key_en) begin
        force_q <= force_d;
      end
      if (ctrl_i.tick_en) begin
        velocity_q <= vel_new;
      end
      if (ctrl_i.pos_en) begin
        subpixel_q <= subpixel_d;
      end
    end
  end

  // Hold the new velocity for the position stage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.tick_en) begin
      vel_stage_q <= vel_new;
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import kdpm_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned GAP_MAX       = 17;
  localparam int unsigned IN_W          = $bits(kdpm_in_t);

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;
  localparam logic [2:0]           KEY_SPARE_HI = 3'd7;

  localparam longint Q16_ONE = 65536;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Block ports
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  kdpm_in_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  kdpm_out_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [STEP_W-1:0]    cfg_data  = '0;

  key_driven_pointer_motion i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Shadow registers and pointer state
  logic [STEP_W-1:0]    step_reg        = FORCE_STEP_RST;
  logic [FRIC_W-1:0]    fric_normal_reg = FRICTION_NORMAL_RST;
  logic [FRIC_W-1:0]    fric_brake_reg  = FRICTION_BRAKE_RST;
  logic signed [QW-1:0] push_x = '0;
  logic signed [QW-1:0] push_y = '0;
  logic signed [QW-1:0] vel_x  = '0;
  logic signed [QW-1:0] vel_y  = '0;
  logic signed [QW-1:0] pos_x  = '0;
  logic signed [QW-1:0] pos_y  = '0;
  logic                 brake_held = 1'b0;

  kdpm_out_t   move_queue[$];
  bit          idle_en = 1'b1;
  int unsigned stall_left    = 0;
  int unsigned error_count   = 0;
  int unsigned beat_count    = 0;
  int unsigned tick_count    = 0;
  int unsigned move_count    = 0;
  int unsigned write_count   = 0;
  int unsigned setting_count = 0;
  int unsigned cycle_count   = 0;

  // Clamp to the signed 32-bit range
  function automatic logic signed [QW-1:0] clamp_q16(input longint v);
    longint r;
    r = (v > S32_MAX) ? S32_MAX : ((v < S32_MIN) ? S32_MIN : v);
    return r[QW-1:0];
  endfunction

  // One axis of a tick: accelerate, apply friction, move, split off whole pixels
  function automatic logic signed [MOVE_W-1:0] advance_axis(
      input  logic signed [QW-1:0] push,
      input  logic [FRIC_W-1:0]    fric,
      inout  logic signed [QW-1:0] vel,
      inout  logic signed [QW-1:0] pos);
    longint v;
    longint whole;
    longint rest;
    v     = clamp_q16(longint'(vel) + longint'(push));
    v     = (v * longint'(fric)) / Q16_ONE;
    vel   = v[QW-1:0];
    pos   = clamp_q16(longint'(pos) + v);
    whole = longint'(pos) / Q16_ONE;
    rest  = longint'(pos) - whole * Q16_ONE;
    pos   = rest[QW-1:0];
    return whole[MOVE_W-1:0];
  endfunction

  // Update the pointer state for one accepted beat and queue any move
  task automatic advance_pointer(input kdpm_in_t beat);
    longint            step;
    logic [FRIC_W-1:0] fric;
    kdpm_out_t         move;
    step = beat.pressed ? longint'(step_reg) : -longint'(step_reg);
    if (beat.command == CMD_KEY) begin
      case (beat.key_code)
        KEY_LEFT:  push_x = clamp_q16(longint'(push_x) - step);
        KEY_RIGHT: push_x = clamp_q16(longint'(push_x) + step);
        KEY_UP:    push_y = clamp_q16(longint'(push_y) - step);
        KEY_DOWN:  push_y = clamp_q16(longint'(push_y) + step);
        KEY_BRAKE: brake_held = beat.pressed;
        default: begin
        end
      endcase
      if (beat.key_code <= KEY_BRAKE) begin
        beat_count++;
      end
    end else begin
      beat_count++;
      tick_count++;
      fric = brake_held ? fric_brake_reg : fric_normal_reg;
      move.move_x = advance_axis(push_x, fric, vel_x, pos_x);
      move.move_y = advance_axis(push_y, fric, vel_y, pos_y);
      if (move.move_x != 0 || move.move_y != 0) begin
        move_queue.push_back(move);
      end
    end
  endtask

  function automatic kdpm_in_t key_beat(input logic [2:0] code, input logic down);
    kdpm_in_t b;
    b.command  = CMD_KEY;
    b.key_code = code;
    b.pressed  = down;
    return b;
  endfunction

  // Key code and pressed carry junk on a tick
  function automatic kdpm_in_t tick_beat();
    kdpm_in_t b;
    b.command  = CMD_TICK;
    b.key_code = 3'($urandom_range(KEY_LEFT, KEY_SPARE_HI));
    b.pressed  = 1'($urandom);
    return b;
  endfunction

  // Send one beat, with an optional idle burst ahead of it
  task automatic send_beat(input kdpm_in_t beat);
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, GAP_MAX)) @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data  = beat;
    do @(posedge clk_i); while (!in_ready);
    advance_pointer(beat);
  endtask

  // Hold off input until every move is in and the pipeline has emptied
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (move_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_index,
                           input logic [STEP_W-1:0] value);
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_index = reg_index;
    cfg_data  = value;
    do @(posedge clk_i); while (!cfg_ready);
    case (reg_index)
      CFG_FORCE_STEP:      step_reg        = value;
      CFG_FRICTION_NORMAL: fric_normal_reg = value[FRIC_W-1:0];
      CFG_FRICTION_BRAKE:  fric_brake_reg  = value[FRIC_W-1:0];
      default: begin
      end
    endcase
    write_count++;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // Friction writes carry random junk in the unused upper bits
  task automatic load_settings(input logic [STEP_W-1:0] step,
                               input logic [FRIC_W-1:0] normal,
                               input logic [FRIC_W-1:0] brake);
    wait_idle();
    write_reg(CFG_FORCE_STEP, step);
    write_reg(CFG_FRICTION_NORMAL, {8'($urandom), normal});
    write_reg(CFG_FRICTION_BRAKE, {8'($urandom), brake});
    setting_count++;
  endtask

  // Mostly press, tick, release gestures; the rest is raw noise
  task automatic run_traffic(input int unsigned beats);
    int unsigned                 target;
    logic [2:0]                  first;
    logic [2:0]                  second;
    bit                          dual;
    logic [$bits(kdpm_in_t)-1:0] raw;
    target = beat_count + beats;
    while (beat_count < target) begin
      if ($urandom_range(0, 9) < 7) begin
        first  = 3'($urandom_range(KEY_LEFT, KEY_BRAKE));
        second = 3'($urandom_range(KEY_LEFT, KEY_BRAKE));
        dual   = ($urandom_range(0, 2) == 0);
        send_beat(key_beat(first, 1'b1));
        if (dual) begin
          send_beat(key_beat(second, 1'b1));
        end
        repeat ($urandom_range(1, 10)) send_beat(tick_beat());
        send_beat(key_beat(first, 1'b0));
        if (dual) begin
          send_beat(key_beat(second, 1'b0));
        end
        repeat ($urandom_range(0, 4)) send_beat(tick_beat());
      end else begin
        raw = IN_W'($urandom);
        send_beat(raw);
      end
    end
  endtask

  // Every key both ways at reset settings, brake, unmatched releases, spare codes
  task automatic test_directed();
    send_beat(key_beat(KEY_RIGHT, 1'b1));
    repeat (3) send_beat(tick_beat());
    send_beat(key_beat(KEY_BRAKE, 1'b1));
    repeat (2) send_beat(tick_beat());
    send_beat(key_beat(KEY_BRAKE, 1'b0));
    send_beat(key_beat(KEY_UP, 1'b1));
    repeat (2) send_beat(tick_beat());
    send_beat(key_beat(KEY_RIGHT, 1'b0));
    send_beat(key_beat(KEY_UP, 1'b0));
    send_beat(key_beat(KEY_LEFT, 1'b1));
    send_beat(key_beat(KEY_DOWN, 1'b1));
    repeat (2) send_beat(tick_beat());
    send_beat(key_beat(KEY_LEFT, 1'b0));
    send_beat(key_beat(KEY_LEFT, 1'b0));
    send_beat(key_beat(KEY_DOWN, 1'b0));
    send_beat(key_beat(KEY_BRAKE + 3'd1, 1'b1));
    send_beat(key_beat(KEY_SPARE_HI - 3'd1, 1'b0));
    send_beat(key_beat(KEY_SPARE_HI, 1'b1));
    repeat (3) send_beat(tick_beat());
  endtask

  // Drive x to the top of its range and y to the bottom, then walk both back
  task automatic test_saturation();
    load_settings({STEP_W{1'b1}}, {FRIC_W{1'b1}}, '0);
    write_reg(CFG_SPARE, STEP_W'($urandom));
    for (int i = 0; i < 130; i++) begin
      send_beat(key_beat(KEY_RIGHT, 1'b1));
      send_beat(key_beat(KEY_UP, 1'b1));
      if (i % 8 == 7) begin
        send_beat(tick_beat());
      end
    end
    repeat (6) send_beat(tick_beat());
    send_beat(key_beat(KEY_BRAKE, 1'b1));
    repeat (2) send_beat(tick_beat());
    send_beat(key_beat(KEY_BRAKE, 1'b0));
    repeat (2) send_beat(tick_beat());
    // 128 full steps bring each force back near zero
    for (int i = 0; i < 128; i++) begin
      send_beat(key_beat(KEY_RIGHT, 1'b0));
      send_beat(key_beat(KEY_UP, 1'b0));
      if (i % 8 == 7) begin
        send_beat(tick_beat());
      end
    end
    repeat (6) send_beat(tick_beat());
  endtask

  // No force per key, full stop without brake, almost no decay with it
  task automatic test_zero_step();
    load_settings('0, '0, {FRIC_W{1'b1}});
    run_traffic(100);
  endtask

  // Random settings; pause in the middle of the second phase until all moves have drained
  task automatic test_random_settings();
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 3) begin
        load_settings(STEP_W'($urandom), FRIC_W'($urandom), FRIC_W'($urandom));
      end else begin
        load_settings(STEP_W'($urandom_range(1, 24'h3FFFF)), FRIC_W'($urandom),
                      FRIC_W'($urandom));
      end
      run_traffic(80);
      if (phase == 1) begin
        wait_idle();
      end
      run_traffic(80);
    end
  endtask

  // Back to reset values, no idling on either side
  task automatic test_steady_stream();
    load_settings(FORCE_STEP_RST, FRICTION_NORMAL_RST, FRICTION_BRAKE_RST);
    idle_en = 1'b0;
    run_traffic(250);
  endtask

  // Output back-pressure in random bursts
  always @(negedge clk_i) begin
    if (!idle_en) begin
      stall_left = 0;
      out_ready  = 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready = 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, GAP_MAX - 1);
      out_ready  = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  // Check each move beat against the oldest prediction
  always @(posedge clk_i) begin
    kdpm_out_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (move_queue.size() == 0) begin
        error_count++;
        $display("%0t: unexpected move: expected none, actual x=%0d y=%0d",
                 $time, out_data.move_x, out_data.move_y);
      end else begin
        want = move_queue.pop_front();
        move_count++;
        if (out_data.move_x !== want.move_x) begin
          error_count++;
          $display("%0t: move_x mismatch: expected %0d, actual %0d",
                   $time, want.move_x, out_data.move_x);
        end
        if (out_data.move_y !== want.move_y) begin
          error_count++;
          $display("%0t: move_y mismatch: expected %0d, actual %0d",
                   $time, want.move_y, out_data.move_y);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_saturation();
    test_zero_step();
    test_random_settings();
    test_steady_stream();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (move_queue.size() != 0) begin
      error_count++;
      $display("%0t: %0d moves never arrived", $time, move_queue.size());
    end
    $display("Drove %0d key and tick beats (%0d ticks) under %0d register settings, %0d writes.",
             beat_count, tick_count, setting_count, write_count);
    $display("Checked %0d moves, saturated force, velocity and position included.",
             move_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
